/* rtl/core/spem_pkg.sv */
// Shared types and constants for the stereo peak envelope meter.
// No dependencies; the core module refers to these by scoped names.
package spem_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_SAMPLES_PER_WINDOW = 2'd0;
  localparam logic [1:0] REG_WINDOWS_TO_AVERAGE = 2'd1;

  // Register reset values.
  localparam logic [15:0] SPW_RESET = 16'd882;
  localparam logic [7:0]  WTA_RESET = 8'd1;

  // Level scale: hundredths of a percent of full scale (2^15).
  localparam logic [13:0] LEVEL_SCALE      = 14'd10000;
  localparam int          FULL_SCALE_SHIFT = 15;

  // Scaled sum: peak_sum * 10000 >> 15 stays below 2^22.
  localparam int DIVIDEND_W = 22;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);

endpackage

/* rtl/core/stereo_peak_envelope_meter.sv */
// Stereo peak envelope meter: top level with sample tracking and a serial divider.
// Depends on spem_pkg for the state type, register indexes and scale constants.

// Each accepted request carries one signed 16-bit stereo pair. The block takes
// the larger of the two magnitudes, keeps the peak of the current window, and
// adds each finished window peak into a group sum. When the configured number
// of windows has closed, it emits one level, floor(sum * 10000 / (windows *
// 32768)), in the range 0 to 10000. A request with restart set drops the
// partial window and group before its own sample is counted. A request that
// does not close a group is absorbed in the cycle it is accepted, so such
// requests can stream at one per clock. A request that closes a group holds
// off the next one until its level is out: the request is accepted and the
// window and group updated, the constant multiplier scales the sum, a
// restoring divider produces one quotient bit per cycle, and the level is
// handed to the output register. If the previous level is still waiting on
// out_stall at that point, the block holds until it is taken.
// Configuration writes are always accepted and should only be issued while
// the block is idle; they do not clear the running window or group.
module stereo_peak_envelope_meter (
  input  logic        clk,
  input  logic        rst_n,
  // Sample channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_left_sample,
  input  logic [15:0] in_right_sample,
  input  logic        in_restart,
  // Level channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] out_level,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int DW = spem_pkg::DIVIDEND_W;
  localparam int CW = spem_pkg::CNT_W;

  // Sequencer and configuration.
  spem_pkg::state_t state_r, state_nxt;
  logic [15:0] spw_r;
  logic [7:0]  wta_r;

  // Running window and group state.
  logic [15:0] window_peak_r, window_peak_nxt;
  logic [23:0] peak_sum_r, peak_sum_nxt;
  logic [15:0] sample_count_r, sample_count_nxt;
  logic [7:0]  window_count_r, window_count_nxt;

  // Divider datapath.
  logic [23:0]   grp_sum_r, grp_sum_nxt;
  logic [7:0]    divisor_r, divisor_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [7:0]    rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [13:0] out_level_r, out_level_nxt;

  // Sample path signals.
  logic        in_fire;
  logic [16:0] left_mag, right_mag;
  logic [15:0] pair_mag, base_peak, new_peak;
  logic [15:0] base_count, next_count, spw_eff;
  logic [23:0] base_sum, next_sum;
  logic [7:0]  base_windows, next_windows, wta_eff;

  // Divider step signals.
  logic [37:0] scaled_prod;
  logic [8:0]  rem_shift;
  logic        rem_ge;
  logic [13:0] level_final;

  assign in_stall  = (state_r != spem_pkg::ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_level = out_level_r;

  // Magnitude of a 16-bit two's complement value; -32768 gives 32768.
  assign left_mag  = in_left_sample[15]  ? (17'h10000 - {1'b0, in_left_sample})
                                         : {1'b0, in_left_sample};
  assign right_mag = in_right_sample[15] ? (17'h10000 - {1'b0, in_right_sample})
                                         : {1'b0, in_right_sample};
  assign pair_mag  = (left_mag > right_mag) ? left_mag[15:0] : right_mag[15:0];

  // A restart request starts from an empty window and group.
  assign base_peak    = in_restart ? 16'd0 : window_peak_r;
  assign base_count   = in_restart ? 16'd0 : sample_count_r;
  assign base_sum     = in_restart ? 24'd0 : peak_sum_r;
  assign base_windows = in_restart ? 8'd0  : window_count_r;

  assign new_peak     = (pair_mag > base_peak) ? pair_mag : base_peak;
  assign next_count   = base_count + 16'd1;
  assign next_sum     = base_sum + {8'd0, new_peak};
  assign next_windows = base_windows + 8'd1;

  // A register value of zero behaves as one.
  assign spw_eff = (spw_r == 16'd0) ? 16'd1 : spw_r;
  assign wta_eff = (wta_r == 8'd0)  ? 8'd1  : wta_r;

  // Sum scaled to hundredths of a percent, with the full-scale factor of
  // 2^15 divided out first; the window count divides the remainder.
  assign scaled_prod = {14'd0, grp_sum_r} * {24'd0, spem_pkg::LEVEL_SCALE};

  // One restoring-division step: bring down the next dividend bit.
  assign rem_shift = {rem_r, quo_r[DW-1]};
  assign rem_ge    = (rem_shift >= {1'b0, divisor_r});

  // Peaks never exceed full scale, so the clamp only guards the bound.
  always_comb begin
    if (divisor_r == 8'd0) begin
      level_final = 14'd0;
    end else if (quo_r > DW'(spem_pkg::LEVEL_SCALE)) begin
      level_final = spem_pkg::LEVEL_SCALE;
    end else begin
      level_final = quo_r[13:0];
    end
  end

  always_comb begin
    state_nxt        = state_r;
    window_peak_nxt  = window_peak_r;
    peak_sum_nxt     = peak_sum_r;
    sample_count_nxt = sample_count_r;
    window_count_nxt = window_count_r;
    grp_sum_nxt      = grp_sum_r;
    divisor_nxt      = divisor_r;
    quo_nxt          = quo_r;
    rem_nxt          = rem_r;
    cnt_nxt          = cnt_r;
    out_level_nxt    = out_level_r;
    out_valid_nxt    = out_valid_r && out_stall;

    unique case (state_r)
      spem_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (next_count < spw_eff) begin
            window_peak_nxt  = new_peak;
            sample_count_nxt = next_count;
            peak_sum_nxt     = base_sum;
            window_count_nxt = base_windows;
          end else begin
            window_peak_nxt  = 16'd0;
            sample_count_nxt = 16'd0;
            if (next_windows < wta_eff) begin
              peak_sum_nxt     = next_sum;
              window_count_nxt = next_windows;
            end else begin
              // Group closes: hand the sum and count to the divider.
              peak_sum_nxt     = 24'd0;
              window_count_nxt = 8'd0;
              grp_sum_nxt      = next_sum;
              divisor_nxt      = next_windows;
              state_nxt        = spem_pkg::ST_MUL;
            end
          end
        end
      end
      spem_pkg::ST_MUL: begin
        quo_nxt   = scaled_prod[spem_pkg::FULL_SCALE_SHIFT +: DW];
        rem_nxt   = 8'd0;
        cnt_nxt   = CW'(spem_pkg::DIV_STEPS - 1);
        state_nxt = spem_pkg::ST_DIV;
      end
      spem_pkg::ST_DIV: begin
        rem_nxt = rem_ge ? 8'(rem_shift - {1'b0, divisor_r}) : rem_shift[7:0];
        quo_nxt = {quo_r[DW-2:0], rem_ge};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          state_nxt = spem_pkg::ST_DONE;
        end
      end
      spem_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_level_nxt = level_final;
          out_valid_nxt = 1'b1;
          state_nxt     = spem_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = spem_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= spem_pkg::ST_IDLE;
      spw_r          <= spem_pkg::SPW_RESET;
      wta_r          <= spem_pkg::WTA_RESET;
      window_peak_r  <= 16'd0;
      peak_sum_r     <= 24'd0;
      sample_count_r <= 16'd0;
      window_count_r <= 8'd0;
      cnt_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      window_peak_r  <= window_peak_nxt;
      peak_sum_r     <= peak_sum_nxt;
      sample_count_r <= sample_count_nxt;
      window_count_r <= window_count_nxt;
      cnt_r          <= cnt_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          spem_pkg::REG_SAMPLES_PER_WINDOW: spw_r <= cfg_data;
          spem_pkg::REG_WINDOWS_TO_AVERAGE: wta_r <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    grp_sum_r   <= grp_sum_nxt;
    divisor_r   <= divisor_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    out_level_r <= out_level_nxt;
  end

  // A level never exceeds full scale.
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_level_r <= spem_pkg::LEVEL_SCALE))
    else $error("level above full scale");

  // A new level only appears after the divider has finished.
  a_level_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == spem_pkg::ST_DONE))
    else $error("level raised outside the finish state");

  // The last division step always leads to the finish state.
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spem_pkg::ST_DIV && cnt_r == '0) |=> (state_r == spem_pkg::ST_DONE))
    else $error("divider overran its step count");

endmodule

/* dv/spem_level_checker.sv */
// Level checker for the stereo peak envelope meter: watches all three channels,
// predicts each level from the accepted samples and compares it on the output.
// Depends on spem_pkg for register indexes, reset values and the level scale.
module spem_level_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] in_left_sample,
  input  logic [15:0] in_right_sample,
  input  logic        in_restart,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [13:0] out_level,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int unsigned fail_count,
  output int unsigned levels_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] FULL_SCALE = 64'd1 << spem_pkg::FULL_SCALE_SHIFT;

  logic [15:0] window_len;
  logic [7:0]  group_len;
  logic [15:0] peak_now;
  logic [23:0] peak_total;
  logic [15:0] samples_seen;
  logic [7:0]  windows_seen;
  logic [13:0] expected_levels[$];
  logic [13:0] oldest_level;
  int unsigned mismatches = 0;
  int unsigned queued = 0;

  assign fail_count     = mismatches;
  assign levels_pending = queued;

  function automatic logic [15:0] magnitude(input logic [15:0] s);
    return s[15] ? (~s + 16'd1) : s;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ns level check: %s, got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic take_sample(input logic [15:0] l, input logic [15:0] r, input logic rs);
    logic [15:0] eff_window;
    logic [7:0]  eff_group;
    logic [15:0] ml;
    logic [15:0] mr;
    logic [15:0] m;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] lvl;
    eff_window = (window_len == 16'd0) ? 16'd1 : window_len;
    eff_group  = (group_len == 8'd0) ? 8'd1 : group_len;
    if (rs) begin
      peak_now     = '0;
      peak_total   = '0;
      samples_seen = '0;
      windows_seen = '0;
    end
    ml = magnitude(l);
    mr = magnitude(r);
    m  = (ml > mr) ? ml : mr;
    if (m > peak_now) peak_now = m;
    samples_seen = samples_seen + 16'd1;
    if (samples_seen < eff_window) return;
    peak_total   = peak_total + {8'd0, peak_now};
    peak_now     = '0;
    samples_seen = '0;
    windows_seen = windows_seen + 8'd1;
    if (windows_seen < eff_group) return;
    // The divisor is the count of windows really summed, not the register.
    num = 64'(peak_total) * 64'(spem_pkg::LEVEL_SCALE);
    den = 64'(windows_seen) * FULL_SCALE;
    lvl = (den != 0) ? num / den : 64'd0;
    if (lvl > 64'(spem_pkg::LEVEL_SCALE)) lvl = 64'(spem_pkg::LEVEL_SCALE);
    expected_levels.push_back(lvl[13:0]);
    peak_total   = '0;
    windows_seen = '0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      window_len   = spem_pkg::SPW_RESET;
      group_len    = spem_pkg::WTA_RESET;
      peak_now     = '0;
      peak_total   = '0;
      samples_seen = '0;
      windows_seen = '0;
      expected_levels.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_levels.size() == 0) begin
          report_mismatch("level with no sample awaiting it", 32'(out_level), 0);
        end else begin
          oldest_level = expected_levels.pop_front();
          if (out_level !== oldest_level)
            report_mismatch("level", 32'(out_level), 32'(oldest_level));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == spem_pkg::REG_SAMPLES_PER_WINDOW)
          window_len = cfg_data;
        else if (cfg_index == spem_pkg::REG_WINDOWS_TO_AVERAGE)
          group_len = cfg_data[7:0];
      end
      if (in_valid && !in_stall)
        take_sample(in_left_sample, in_right_sample, in_restart);
    end
    queued = expected_levels.size();
  end

endmodule

/* dv/tb.sv */
// Top of the stereo peak envelope meter testbench: clock, reset, sample and
// configuration stimulus, output stall pattern and the final verdict.
// Depends on spem_pkg, the meter RTL and spem_level_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Indexes past the two real registers; writes there must change nothing.
  localparam logic [1:0] REG_SPARE_LO = 2'd2;
  localparam logic [1:0] REG_SPARE_HI = 2'd3;

  localparam int RANDOM_ITEMS  = 1250;
  // Settle time after the last level; a closing request finishes within it.
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int HOLD_OFF      = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_left_sample = '0;
  logic [15:0] in_right_sample = '0;
  logic        in_restart = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [13:0] out_level;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int unsigned fail_count;
  int unsigned levels_pending;
  // Cycles of forced output stall still to run; set by the stimulus,
  // counted down by the stall process.
  int hold_cycles = 0;

  always #4 clk = ~clk;

  stereo_peak_envelope_meter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_level       (out_level),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  spem_level_checker level_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_level       (out_level),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .levels_pending  (levels_pending)
  );

  // Offer one sample request and return at the edge where it is taken. The
  // valid is left high, so back-to-back calls stream without a bubble. The
  // stall is read right after the edge, before any register of the block
  // has moved, so it is the value that the edge itself saw.
  task automatic push_sample(input logic [15:0] l, input logic [15:0] r, input logic rs);
    in_valid        <= 1'b1;
    in_left_sample  <= l;
    in_right_sample <= r;
    in_restart      <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_gap(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Registers may only change while the block is idle: every predicted level
  // has been taken and a closing request would have finished by now.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (levels_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [15:0] data);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Group length goes in the low byte; the high byte is junk the block drops.
  task automatic set_group(input logic [7:0] windows);
    set_reg(spem_pkg::REG_WINDOWS_TO_AVERAGE, {8'($urandom), windows});
  endtask

  // Samples lean on the corners of the signed range and on tiny values,
  // with plenty of full-range noise so every bit toggles.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      4, 5:    return 16'($urandom_range(0, 128)) - 16'd64;
      default: return 16'($urandom);
    endcase
  endfunction

  // The receiver runs through stretches of its own: no stall, light random
  // stall, a fixed periodic pattern, and heavy random stall. A requested
  // hold-off overrides all of them.
  initial begin : stall_pattern
    int mode;
    int stretch;
    int tick;
    mode = 0;
    stretch = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        if (stretch == 0) begin
          mode = $urandom_range(0, 3);
          stretch = $urandom_range(20, 200);
        end
        stretch--;
        tick++;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 99) < 30);
          2:       out_stall <= (tick % 3 == 0);
          default: out_stall <= ($urandom_range(0, 99) < 85);
        endcase
      end
    end
  end

  // Hard stop far beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int random_done;
    int phase;
    int phase_len;
    int burst_left;
    int gap;
    int drain;
    logic [15:0] spw;
    logic [7:0]  wta;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // At the reset settings a window is 882 samples long, so these two only
    // start a window. Lowering the window to one sample then closes it on
    // the very next request, carrying the peak of the first two along.
    push_sample(16'h1234, 16'hfedc, 1'b0);
    push_sample(16'h0042, 16'hff00, 1'b0);
    set_reg(spem_pkg::REG_SAMPLES_PER_WINDOW, 16'd1);

    // One level per request now: both full-scale negatives, full-scale
    // positive, silence, small values of both signs, and a restart.
    push_sample(16'h8000, 16'h0000, 1'b0);
    push_sample(16'h0000, 16'h8000, 1'b0);
    push_sample(16'h7fff, 16'h7fff, 1'b0);
    push_sample(16'h0000, 16'h0000, 1'b0);
    push_sample(16'hffff, 16'h0001, 1'b0);
    push_sample(16'h8001, 16'h0005, 1'b0);
    push_sample(16'h0001, 16'hfffe, 1'b0);
    push_sample(16'h4000, 16'hc000, 1'b1);

    // Writes to the spare indexes are dropped, and zero in either register
    // behaves like one.
    set_reg(REG_SPARE_LO, 16'($urandom));
    set_reg(REG_SPARE_HI, 16'($urandom));
    set_reg(spem_pkg::REG_SAMPLES_PER_WINDOW, 16'd0);
    set_group(8'd0);
    push_sample(16'h2000, 16'h9000, 1'b0);
    push_sample(16'h0100, 16'h7000, 1'b0);

    // Longest window, then shortened mid-window: the window closes as soon
    // as its count reaches or passes the new length.
    set_reg(spem_pkg::REG_SAMPLES_PER_WINDOW, 16'hffff);
    set_group(8'd2);
    push_sample(16'h0fff, 16'hf001, 1'b0);
    push_sample(16'h8000, 16'h0000, 1'b0);
    push_sample(16'h0010, 16'h0020, 1'b0);
    push_sample(16'h5555, 16'haaaa, 1'b0);
    set_reg(spem_pkg::REG_SAMPLES_PER_WINDOW, 16'd3);
    push_sample(16'h0001, 16'h0002, 1'b0);
    push_sample(16'h3000, 16'h0003, 1'b0);
    push_sample(16'hd000, 16'h0004, 1'b1);
    push_sample(16'h0100, 16'h0200, 1'b0);
    push_sample(16'h0300, 16'h0400, 1'b0);
    push_sample(16'h7fff, 16'h0000, 1'b0);
    push_sample(16'h0000, 16'h1000, 1'b0);

    // One window of the group is in; shrinking the group now closes it at
    // the next window, and the mean is taken over both windows.
    set_group(8'd1);
    push_sample(16'h6000, 16'h0000, 1'b0);
    push_sample(16'h0000, 16'ha000, 1'b0);
    push_sample(16'h0007, 16'h0008, 1'b0);

    // Random phases, each under its own setting. Most requests are plain
    // samples so groups run to completion; a few restarts break them up.
    random_done = 0;
    phase = 0;
    while (random_done < RANDOM_ITEMS) begin
      if (phase == 0) begin
        spw = 16'd1;
        wta = 8'd1;
        phase_len = 80;
      end else if (phase == 1) begin
        spw = 16'd1;
        wta = 8'd255;
        phase_len = 300;
      end else begin
        case ($urandom_range(0, 5))
          0: begin
            spw = 16'($urandom_range(1, 4));
            wta = 8'($urandom_range(1, 4));
          end
          1: begin
            spw = 16'($urandom_range(0, 2));
            wta = 8'($urandom_range(0, 2));
          end
          2: begin
            spw = 16'($urandom_range(1, 16));
            wta = 8'($urandom_range(1, 16));
          end
          3: begin
            spw = 16'($urandom_range(1, 60));
            wta = 8'd1;
          end
          4: begin
            spw = 16'($urandom_range(1, 3));
            wta = 8'($urandom_range(1, 40));
          end
          default: begin
            spw = 16'd2;
            wta = 8'd3;
          end
        endcase
        phase_len = $urandom_range(60, 150);
      end
      set_reg(spem_pkg::REG_SAMPLES_PER_WINDOW, spw);
      set_group(wta);

      // In the first phase every request closes a group. Holding the
      // receiver off for a long stretch while requests keep coming fills
      // the output register and the divider, so the input has to stall.
      if (phase == 0) hold_cycles = HOLD_OFF;

      burst_left = 0;
      for (int i = 0; i < phase_len && random_done < RANDOM_ITEMS; i++) begin
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          if (gap > 0) idle_gap(gap);
          burst_left = $urandom_range(1, 24);
        end
        push_sample(pick_sample(), pick_sample(), ($urandom_range(0, 99) < 2));
        burst_left--;
        random_done++;
      end
      phase++;
    end

    // Let the last levels come out, then give the block time to show any
    // level that nobody asked for.
    in_valid <= 1'b0;
    drain = 0;
    @(posedge clk);
    while (levels_pending != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && levels_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/spem_pkg.sv
rtl/core/stereo_peak_envelope_meter.sv
dv/spem_level_checker.sv
dv/tb.sv
